// ===== src/gkst_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid spanning-tree package
// Types, command and status bundles and fixed field widths shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package gkst_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned EdgeW    = 13;
  localparam int unsigned CellOutW = 12;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_HEIGHT = 1'd1;

  // Input action codes.
  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CfgDataW-1:0] GRID_DIM_RESET = 7'd16;

  // Controller states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_GEOM,
    ST_CHECK,
    ST_DIV,
    ST_PAIR,
    ST_RD_A,
    ST_RD_B,
    ST_CMP,
    ST_SCAN,
    ST_CLEAR,
    ST_RESP
  } gkst_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic geom_load;
    logic clr_start;
    logic clr_step;
    logic set_inval;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic pair;
    logic rd_a;
    logic rd_b;
    logic scan_start;
    logic scan_step;
    logic merge;
    logic out_load;
  } gkst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic clr_last;
    logic invalid;
    logic div_done;
    logic in_grid;
    logic labels_differ;
    logic scan_done;
    logic out_free;
  } gkst_stat_t;

endpackage

// ===== src/gkst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Grid spanning-tree controller
// Sequences the label sweep, the edge decode, the two label reads, the
// relabelling scan and the hand-over of each result to the output register.
// ----------------------------------------------------------------------------
module gkst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gkst_pkg::gkst_stat_t stat_i,
  output gkst_pkg::gkst_cmd_t  cmd_o
);
  import gkst_pkg::*;

  gkst_state_e state_q, state_d;

  // State register; reset starts with the label sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_GEOM;
        end
      end
      ST_GEOM: begin
        cmd_o.geom_load = 1'b1;
        if (stat_i.action == ACT_CLEAR) begin
          cmd_o.clr_start = 1'b1;
          state_d         = ST_CLEAR;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.invalid) begin
          cmd_o.set_inval = 1'b1;
          state_d         = ST_RESP;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_fin = 1'b1;
          state_d       = ST_PAIR;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_PAIR: begin
        cmd_o.pair = 1'b1;
        state_d    = ST_RD_A;
      end
      ST_RD_A: begin
        if (stat_i.in_grid) begin
          cmd_o.rd_a = 1'b1;
          state_d    = ST_RD_B;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RD_B: begin
        cmd_o.rd_b = 1'b1;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        if (stat_i.labels_differ) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          cmd_o.merge = 1'b1;
          state_d     = ST_RESP;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/gkst_dp.sv =====
// ----------------------------------------------------------------------------
// Grid spanning-tree datapath
// Configuration registers, grid geometry, edge decode by repeated
// subtraction, the set label memory with its relabelling scan, the join
// counter and the output register.
// ----------------------------------------------------------------------------
module gkst_dp #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes
  input  logic                             cfg_valid_i,
  input  logic [gkst_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gkst_pkg::CfgDataW-1:0]    cfg_data_i,
  // Input item payload
  input  logic                             in_action_i,
  input  logic [gkst_pkg::EdgeW-1:0]       in_edge_index_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_wall_removed_o,
  output logic [gkst_pkg::CellOutW-1:0]    out_cell_a_o,
  output logic [gkst_pkg::CellOutW-1:0]    out_cell_b_o,
  output logic                             out_tree_done_o,
  output logic                             out_edge_invalid_o,
  // Controller link
  input  gkst_pkg::gkst_cmd_t              cmd_i,
  output gkst_pkg::gkst_stat_t             stat_o
);
  import gkst_pkg::*;

  localparam int unsigned CellSlots = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CellW     = $clog2(CellSlots);
  localparam int unsigned CntW      = $clog2(CellSlots + 1);
  localparam int unsigned MaxDim    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DimW      = $clog2(MaxDim + 1);
  localparam int unsigned ClW       = (DimW > CfgDataW) ? DimW : CfgDataW;
  localparam int unsigned AW        = (CntW + 1 > EdgeW + 1) ? CntW + 1 : EdgeW + 1;

  // Configuration registers
  logic [CfgDataW-1:0] grid_width_q, grid_height_q;

  // Geometry of the current item
  logic [AW-1:0] w_q, cells_q, horiz_q, vert_q;

  // Item and decode state
  logic             action_q;
  logic [EdgeW-1:0] edge_q;
  logic             hflag_q;
  logic [AW-1:0]    rem_q, base_q, a_q, b_q;
  logic             removed_q, inval_q;

  // Label memory and scan state
  logic [CellW-1:0] label_mem [CellSlots];
  logic [CellW-1:0] rdata_q, la_q, lb_q, pend_addr_q;
  logic             pend_q;
  logic [CntW-1:0]  cnt_q;
  logic [CellW-1:0] join_q;

  // Output register
  logic                out_valid_q;
  logic                res_removed_q, res_done_q, res_inval_q;
  logic [CellOutW-1:0] res_a_q, res_b_q;

  // Clamped grid dimensions
  logic [ClW-1:0]  w_ext, h_ext;
  logic [DimW-1:0] w_eff, h_eff;
  logic [AW-1:0]   e_ext, wm1, a_sum;
  logic            scan_more, out_take;
  logic            mem_we, mem_re;
  logic [CellW-1:0] mem_waddr, mem_wdata, mem_raddr;

  assign w_ext = ClW'(grid_width_q);
  assign h_ext = ClW'(grid_height_q);

  always_comb begin
    if (w_ext < ClW'(2)) begin
      w_eff = DimW'(2);
    end else if (w_ext > ClW'(MAX_WIDTH)) begin
      w_eff = DimW'(MAX_WIDTH);
    end else begin
      w_eff = DimW'(w_ext);
    end
    if (h_ext < ClW'(2)) begin
      h_eff = DimW'(2);
    end else if (h_ext > ClW'(MAX_HEIGHT)) begin
      h_eff = DimW'(MAX_HEIGHT);
    end else begin
      h_eff = DimW'(h_ext);
    end
  end

  assign e_ext     = AW'(edge_q);
  assign wm1       = w_q - AW'(1);
  assign a_sum     = base_q + rem_q;
  assign scan_more = AW'(cnt_q) < cells_q;
  assign out_take  = out_valid_q && out_ready_i;

  // Status towards the controller
  always_comb begin
    stat_o               = '0;
    stat_o.action        = action_q;
    stat_o.clr_last      = (cnt_q == CntW'(CellSlots - 1));
    stat_o.invalid       = (e_ext >= horiz_q + vert_q);
    stat_o.div_done      = !hflag_q || (rem_q < wm1);
    stat_o.in_grid       = (a_q < cells_q) && (b_q < cells_q);
    stat_o.labels_differ = (la_q != rdata_q);
    stat_o.scan_done     = !scan_more && !pend_q;
    stat_o.out_free      = !out_valid_q || out_ready_i;
  end

  // Memory port selection: sweep or scan writes, decode or scan reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[CellW-1:0];
    mem_wdata = cnt_q[CellW-1:0];
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.scan_step && pend_q && (rdata_q == lb_q)) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = la_q;
    end
    mem_re    = 1'b0;
    mem_raddr = cnt_q[CellW-1:0];
    if (cmd_i.rd_a) begin
      mem_re    = 1'b1;
      mem_raddr = a_q[CellW-1:0];
    end else if (cmd_i.rd_b) begin
      mem_re    = 1'b1;
      mem_raddr = b_q[CellW-1:0];
    end else if (cmd_i.scan_step && scan_more) begin
      mem_re = 1'b1;
    end
  end

  // Set label memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      label_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= label_mem[mem_raddr];
    end
  end

  // Control registers: configuration, sweep and scan counter, join count,
  // output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_DIM_RESET;
      grid_height_q <= GRID_DIM_RESET;
      cnt_q         <= '0;
      pend_q        <= 1'b0;
      join_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
          REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_start || cmd_i.scan_start) begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.clr_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.scan_step) begin
        pend_q <= scan_more;
        if (scan_more) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.clr_start) begin
        join_q <= '0;
      end else if (cmd_i.merge && (join_q != '1)) begin
        join_q <= join_q + CellW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the item in work and of the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q  <= in_action_i;
      edge_q    <= in_edge_index_i;
      a_q       <= '0;
      b_q       <= '0;
      removed_q <= 1'b0;
      inval_q   <= 1'b0;
    end
    if (cmd_i.geom_load) begin
      w_q     <= AW'(w_eff);
      cells_q <= AW'(w_eff) * AW'(h_eff);
      horiz_q <= AW'(h_eff) * (AW'(w_eff) - AW'(1));
      vert_q  <= AW'(w_eff) * (AW'(h_eff) - AW'(1));
    end
    if (cmd_i.set_inval) begin
      inval_q <= 1'b1;
    end
    // Edge decode: a horizontal edge is divided by width - 1 through repeated
    // subtraction, a vertical edge is offset past the horizontal ones.
    if (cmd_i.div_init) begin
      hflag_q <= (e_ext < horiz_q);
      rem_q   <= (e_ext < horiz_q) ? e_ext : (e_ext - horiz_q);
      base_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_q - wm1;
      base_q <= base_q + w_q;
    end
    if (cmd_i.div_fin) begin
      a_q <= a_sum;
    end
    if (cmd_i.pair) begin
      b_q <= a_q + (hflag_q ? AW'(1) : w_q);
    end
    if (cmd_i.rd_b) begin
      la_q <= rdata_q;
    end
    if (cmd_i.scan_start) begin
      lb_q <= rdata_q;
    end
    if (cmd_i.scan_step) begin
      pend_addr_q <= cnt_q[CellW-1:0];
    end
    if (cmd_i.merge) begin
      removed_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      res_removed_q <= removed_q;
      res_a_q       <= CellOutW'(a_q);
      res_b_q       <= CellOutW'(b_q);
      res_done_q    <= (AW'(join_q) >= cells_q - AW'(1));
      res_inval_q   <= inval_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_wall_removed_o = res_removed_q;
  assign out_cell_a_o       = res_a_q;
  assign out_cell_b_o       = res_b_q;
  assign out_tree_done_o    = res_done_q;
  assign out_edge_invalid_o = res_inval_q;

endmodule

// ===== src/grid_kruskal_spanning_tree_unit.sv =====
// ----------------------------------------------------------------------------
// Grid Kruskal spanning-tree unit
// Keeps one set label per grid cell and joins the sets of the two cells of
// each edge offered by the host, relabelling one set by a scan of all grid cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//  in        in         in_valid_i/in_ready_o   in_action_i, in_edge_index_i
//  out       out        out_valid_o/out_ready_i wall_removed, cell_a, cell_b,
//                                               tree_done, edge_invalid
//
//  One item is worked on at a time. A horizontal edge is decoded with one
//  subtraction step per row above it, and an edge whose cells are joined
//  further needs a scan over the width * height labels of the grid. An
//  invalid edge skips the decode and the scan. A clear action rewrites all
//  MAX_WIDTH * MAX_HEIGHT labels, one label written per cycle, and after
//  reset the same sweep runs before the first item is taken. A result
//  waits in the output register while the next item is taken and worked
//  on; that item then stalls in its response state until the register is
//  free. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module grid_kruskal_spanning_tree_unit #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gkst_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gkst_pkg::CfgDataW-1:0] cfg_data_i,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_action_i,
  input  logic [gkst_pkg::EdgeW-1:0]    in_edge_index_i,
  // Results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_wall_removed_o,
  output logic [gkst_pkg::CellOutW-1:0] out_cell_a_o,
  output logic [gkst_pkg::CellOutW-1:0] out_cell_b_o,
  output logic                          out_tree_done_o,
  output logic                          out_edge_invalid_o
);
  import gkst_pkg::*;

  gkst_cmd_t  cmd;
  gkst_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencer
  gkst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath with the label memory
  gkst_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_action_i        (in_action_i),
    .in_edge_index_i    (in_edge_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_wall_removed_o (out_wall_removed_o),
    .out_cell_a_o       (out_cell_a_o),
    .out_cell_b_o       (out_cell_b_o),
    .out_tree_done_o    (out_tree_done_o),
    .out_edge_invalid_o (out_edge_invalid_o),
    .cmd_i              (cmd),
    .stat_o             (stat)
  );

endmodule
